// ===== rtl/core/idp_pkg.sv =====
package idp_pkg;

  // default pool depth
  localparam int POOL_MAX_DEF = 1024;

  // command field
  localparam int CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic start;  // load pool size, restart fill
    logic rd;     // input word taken, issue memory reads
    logic exec;   // update stack and bits, load result
    logic clr;    // clear one in-use entry
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_stall;   // result register full and not drained
    logic clear_done;  // last in-use entry being cleared
  } dp_sts_t;

endpackage

// ===== rtl/core/idp_ctrl.sv =====
module idp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  output idp_pkg::dp_cmd_t  cmd,
  input  idp_pkg::dp_sts_t  sts
);
  import idp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR
  } state_t;

  state_t state;

  // handshakes
  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE) && !cfg_valid;

  // commands to the datapath
  assign cmd.start = cfg_valid;
  assign cmd.rd    = s_tvalid && s_tready;
  assign cmd.exec  = (state == ST_EXEC) && !sts.out_stall;
  assign cmd.clr   = (state == ST_CLEAR);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else if (cfg_valid) begin
      state <= ST_CLEAR;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) state <= ST_EXEC;
        end
        ST_EXEC: begin
          if (!sts.out_stall) state <= ST_IDLE;
        end
        ST_CLEAR: begin
          if (sts.clear_done) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/idp_datapath.sv =====
module idp_datapath #(
  parameter  int POOL_MAX = idp_pkg::POOL_MAX_DEF,
  localparam int ID_W     = $clog2(POOL_MAX),
  localparam int CNT_W    = $clog2(POOL_MAX + 1),
  localparam int IN_W     = ((idp_pkg::CMD_W + ID_W + 7) / 8) * 8,
  localparam int OUT_W    = ((1 + ID_W + CNT_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  idp_pkg::dp_cmd_t  cmd,
  output idp_pkg::dp_sts_t  sts,
  input  logic [CNT_W-1:0]  cfg_data,
  input  logic [IN_W-1:0]   s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata
);
  import idp_pkg::*;

  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(POOL_MAX);

  // memories
  logic [ID_W-1:0] stk_mem [POOL_MAX];
  logic            use_mem [POOL_MAX];

  // input fields
  logic [CMD_W-1:0] in_cmd;
  logic [ID_W-1:0]  in_id;
  assign in_cmd = s_tdata[CMD_W-1:0];
  assign in_id  = s_tdata[CMD_W+ID_W-1:CMD_W];

  // pool state
  logic [CNT_W-1:0] pool_size;
  logic [CNT_W-1:0] stack_count;
  logic [CNT_W-1:0] low_mark;
  logic [CNT_W-1:0] sweep_cnt;

  logic [CNT_W-1:0] cfg_sat;
  logic [CNT_W-1:0] count_m1;
  logic [CNT_W-1:0] count_p1;
  logic             in_range;

  assign cfg_sat  = (cfg_data > MAX_C) ? MAX_C : cfg_data;
  assign count_m1 = stack_count - CNT_W'(1);
  assign count_p1 = stack_count + CNT_W'(1);
  assign in_range = (CNT_W'(in_id) < pool_size) && (CNT_W'(in_id) < MAX_C);

  // latched request and memory read data
  logic [CMD_W-1:0] req_cmd;
  logic [ID_W-1:0]  req_id;
  logic             req_in_range;
  logic             req_fill;
  logic [ID_W-1:0]  req_top_idx;
  logic [ID_W-1:0]  stk_q;
  logic             use_q;

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      req_cmd      <= in_cmd;
      req_id       <= in_id;
      req_in_range <= in_range;
      // entries below the low mark are taken as their own index from the fill
      req_fill     <= count_m1 < low_mark;
      req_top_idx  <= count_m1[ID_W-1:0];
      stk_q        <= stk_mem[count_m1[ID_W-1:0]];
      use_q        <= use_mem[in_id];
    end
  end

  // command decode
  logic [ID_W-1:0] top;
  logic            alloc_ok;
  logic            rel_ok;
  logic            qry_ok;

  assign top = req_fill ? req_top_idx : stk_q;

  always_comb begin
    alloc_ok = 1'b0;
    rel_ok   = 1'b0;
    qry_ok   = 1'b0;
    unique case (req_cmd)
      CMD_ALLOC:   alloc_ok = (stack_count != '0);
      CMD_RELEASE: rel_ok   = req_in_range && use_q && (stack_count < MAX_C);
      CMD_QUERY:   qry_ok   = req_in_range && !use_q;
      default:     ;
    endcase
  end

  // in-use write port
  logic            use_we;
  logic [ID_W-1:0] use_wa;
  logic            use_wd;

  always_comb begin
    use_we = 1'b0;
    use_wa = sweep_cnt[ID_W-1:0];
    use_wd = 1'b0;
    if (cmd.clr) begin
      use_we = 1'b1;
    end else if (cmd.exec && alloc_ok) begin
      use_we = 1'b1;
      use_wa = top;
      use_wd = 1'b1;
    end else if (cmd.exec && rel_ok) begin
      use_we = 1'b1;
      use_wa = req_id;
    end
  end

  always_ff @(posedge clk) begin
    if (use_we) use_mem[use_wa] <= use_wd;
  end

  // push on release
  always_ff @(posedge clk) begin
    if (cmd.exec && rel_ok) stk_mem[stack_count[ID_W-1:0]] <= req_id;
  end

  // counters and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size   <= '0;
      stack_count <= '0;
      low_mark    <= '0;
      sweep_cnt   <= '0;
    end else if (cmd.start) begin
      pool_size   <= cfg_sat;
      stack_count <= cfg_sat;
      low_mark    <= cfg_sat;
      sweep_cnt   <= '0;
    end else begin
      if (cmd.clr) sweep_cnt <= sweep_cnt + CNT_W'(1);
      if (cmd.exec && alloc_ok) begin
        stack_count <= count_m1;
        if (count_m1 < low_mark) low_mark <= count_m1;
      end else if (cmd.exec && rel_ok) begin
        stack_count <= count_p1;
      end
    end
  end

  assign sts.clear_done = ({1'b0, sweep_cnt} + {{CNT_W{1'b0}}, 1'b1}) >= {1'b0, pool_size};

  // result register
  logic             out_valid;
  logic             res_success;
  logic [ID_W-1:0]  res_granted;
  logic [CNT_W-1:0] res_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_success <= alloc_ok || rel_ok || qry_ok;
      res_granted <= alloc_ok ? top : '0;
      if (alloc_ok) res_count <= count_m1;
      else if (rel_ok) res_count <= count_p1;
      else res_count <= stack_count;
    end
  end

  assign sts.out_stall = out_valid && !m_tready;
  assign m_tvalid      = out_valid;
  assign m_tdata       = OUT_W'({res_count, res_granted, res_success});

endmodule

// ===== rtl/core/id_pool_free_list_allocator.sv =====
// Identifier pool: a stack of free ids plus one in-use bit per id. Writing
// pool_size on the cfg channel saturates it to POOL_MAX, loads the stack with
// ids 0 .. size-1 (size-1 on top) and clears the in-use bits; the clearing
// pass walks the in-use memory one entry a cycle over max(pool_size, 1) entries,
// during which s_tready stays low. The stack itself is not swept: entries
// below a low-water mark read back as their own index. Each command word takes
// two steps: the accept cycle issues the registered reads of the stack top
// and the in-use bit, the update step writes the memories as the command needs
// and loads the result register. A new word is taken once that result is loaded,
// while it still waits on m_tready; the next item stalls only if the result
// register is still full when it would be loaded.
module id_pool_free_list_allocator #(
  parameter  int POOL_MAX = idp_pkg::POOL_MAX_DEF,
  localparam int ID_W     = $clog2(POOL_MAX),
  localparam int CNT_W    = $clog2(POOL_MAX + 1),
  localparam int IN_W     = ((idp_pkg::CMD_W + ID_W + 7) / 8) * 8,
  localparam int OUT_W    = ((1 + ID_W + CNT_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  // pool size write
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data,
  // command words
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // command, request_id, zero pad
  // result words
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // success, granted_id, free_count, zero pad
);
  import idp_pkg::*;

  dp_cmd_t ctl_cmd;
  dp_sts_t ctl_sts;

  idp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (ctl_cmd),
    .sts       (ctl_sts)
  );

  idp_datapath #(
    .POOL_MAX (POOL_MAX)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (ctl_cmd),
    .sts      (ctl_sts),
    .cfg_data (cfg_data),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // at most one datapath action per cycle besides a restart
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl_cmd.rd, ctl_cmd.exec, ctl_cmd.clr}))
    else $error("overlapping datapath commands");

  // a taken word blocks the input for its update cycle
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken during update cycle");

  // a pool size write always starts a clearing pass
  assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> (ctl_cmd.clr && !s_tready))
    else $error("fill did not start clearing pass");

  // free count never exceeds the pool depth
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[ID_W+CNT_W:ID_W+1] <= CNT_W'(POOL_MAX)))
    else $error("free count above pool depth");

endmodule

// ===== verif/id_pool_checker.sv =====
`timescale 1ns / 1ps

module id_pool_checker #(
  parameter  int POOL_MAX = idp_pkg::POOL_MAX_DEF,
  localparam int ID_W     = $clog2(POOL_MAX),
  localparam int CNT_W    = $clog2(POOL_MAX + 1),
  localparam int IN_W     = ((idp_pkg::CMD_W + ID_W + 7) / 8) * 8,
  localparam int OUT_W    = ((1 + ID_W + CNT_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // command, request_id, zero pad
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [OUT_W-1:0] m_tdata,   // success, granted_id, free_count, zero pad
  output int               errors,
  output int               pending
);
  import idp_pkg::*;

  typedef struct packed {
    logic             ok;
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] cnt;
  } outcome_t;

  // shadow copy of the pool
  logic [ID_W-1:0]  stack_ids [POOL_MAX];
  bit               id_busy   [POOL_MAX];
  logic [CNT_W-1:0] free_cnt;
  logic [CNT_W-1:0] pool_len;
  outcome_t         due_outcomes [$];

  // size write: saturate, stack 0 .. size-1, all ids free
  function automatic void refill(input logic [CNT_W-1:0] size);
    int n;
    n = (int'(size) > POOL_MAX) ? POOL_MAX : int'(size);
    pool_len = CNT_W'(n);
    for (int i = 0; i < POOL_MAX; i++) begin
      stack_ids[i] = (i < n) ? ID_W'(i) : '0;
      id_busy[i]   = 1'b0;
    end
    free_cnt = CNT_W'(n);
  endfunction

  // apply one command word to the shadow pool, return its result word
  function automatic outcome_t run_pool_cmd(input logic [CMD_W-1:0] cmd,
                                            input logic [ID_W-1:0] id);
    outcome_t o;
    o = '0;
    case (cmd)
      CMD_ALLOC: begin
        if (free_cnt != '0) begin
          free_cnt    = free_cnt - CNT_W'(1);
          o.id        = stack_ids[free_cnt[ID_W-1:0]];
          id_busy[o.id] = 1'b1;
          o.ok        = 1'b1;
        end
      end
      CMD_RELEASE: begin
        if (CNT_W'(id) < pool_len && id_busy[id] && int'(free_cnt) < POOL_MAX) begin
          id_busy[id]         = 1'b0;
          stack_ids[free_cnt[ID_W-1:0]] = id;
          free_cnt            = free_cnt + CNT_W'(1);
          o.ok                = 1'b1;
        end
      end
      CMD_QUERY: begin
        o.ok = (CNT_W'(id) < pool_len) && !id_busy[id];
      end
      default: ;
    endcase
    o.cnt = free_cnt;
    return o;
  endfunction

  // watch all three channels
  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (rst) begin
      refill('0);
      due_outcomes.delete();
    end else begin
      if (cfg_valid && cfg_ready) refill(cfg_data);

      // compare result word against oldest prediction
      if (m_tvalid && m_tready) begin
        got.ok  = m_tdata[0];
        got.id  = m_tdata[ID_W:1];
        got.cnt = m_tdata[ID_W+CNT_W -: CNT_W];
        if (due_outcomes.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, m_tdata);
          errors++;
        end else begin
          want = due_outcomes.pop_front();
          if (got.ok !== want.ok) begin
            $display("%0t: success expected %0d actual %0d", $time, want.ok, got.ok);
            errors++;
          end
          if (got.id !== want.id) begin
            $display("%0t: granted_id expected %0d actual %0d", $time, want.id, got.id);
            errors++;
          end
          if (got.cnt !== want.cnt) begin
            $display("%0t: free_count expected %0d actual %0d", $time, want.cnt,
                     got.cnt);
            errors++;
          end
        end
      end

      // predict result of each accepted command word
      if (s_tvalid && s_tready)
        due_outcomes.push_back(run_pool_cmd(s_tdata[CMD_W-1:0],
                                            s_tdata[CMD_W+ID_W-1:CMD_W]));
    end
    pending <= due_outcomes.size();
  end

endmodule

// ===== verif/id_pool_free_list_allocator_tb.sv =====
`timescale 1ns / 1ps

module id_pool_free_list_allocator_tb;
  import idp_pkg::*;

  localparam int POOL_MAX = POOL_MAX_DEF;
  localparam int ID_W     = $clog2(POOL_MAX);
  localparam int CNT_W    = $clog2(POOL_MAX + 1);
  localparam int IN_W     = ((CMD_W + ID_W + 7) / 8) * 8;
  localparam int OUT_W    = ((1 + ID_W + CNT_W + 7) / 8) * 8;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int STUCK_LIMIT = 6000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;    // command, request_id, zero pad
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;         // success, granted_id, free_count, zero pad

  int errors;
  int pending;
  int idle_pct = 20;
  bit quiet = 1'b0;
  int pool_now = 0;
  int stall_left = 0;
  int stuck_cycles = 0;

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  id_pool_free_list_allocator #(.POOL_MAX(POOL_MAX)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  id_pool_checker #(.POOL_MAX(POOL_MAX)) u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .errors    (errors),
    .pending   (pending)
  );

  // result side back-pressure in random bursts
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
      m_tready   <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      stall_left <= $urandom_range(0, 16);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (s_tvalid && s_tready)
        || (m_tvalid && m_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // one command word, with an optional gap before it
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input int id);
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_W'({ID_W'(id), cmd});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // pool size write once every result word is back
  task automatic set_pool(input int size);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= CNT_W'(size);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    pool_now = (size > POOL_MAX) ? POOL_MAX : size;
  endtask

  // request ids biased toward the top of the pool, which allocations hand out first
  function automatic int pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (pool_now == 0 || r < 10)
      return $urandom_range(0, POOL_MAX - 1);
    if (r < 55)
      return pool_now - 1 - $urandom_range(0, (pool_now > 32) ? 31 : pool_now - 1);
    return $urandom_range(0, (pool_now + 1 > POOL_MAX - 1) ? POOL_MAX - 1 : pool_now + 1);
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return CMD_ALLOC;
    if (r < 75) return CMD_RELEASE;
    if (r < 95) return CMD_QUERY;
    return CMD_UNUSED;
  endfunction

  int phase_size  [9] = '{5, 1, 1024, 2047, 0, 37, 2, 200, 16};
  int phase_items [9] = '{160, 150, 200, 150, 40, 150, 100, 200, 150};
  int phase_idle  [9] = '{30, 0, 15, 40, 30, 10, 50, 20, 0};

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty pool straight out of reset
    send_cmd(CMD_ALLOC, 0);
    send_cmd(CMD_RELEASE, 0);
    send_cmd(CMD_QUERY, 0);
    send_cmd(CMD_UNUSED, POOL_MAX - 1);

    // drain a small pool past empty, then release paths
    set_pool(4);
    repeat (5) send_cmd(CMD_ALLOC, 0);
    send_cmd(CMD_QUERY, 3);
    send_cmd(CMD_RELEASE, 3);
    send_cmd(CMD_RELEASE, 3);   // already free
    send_cmd(CMD_QUERY, 3);
    send_cmd(CMD_RELEASE, 4);   // out of range
    send_cmd(CMD_QUERY, POOL_MAX - 1);
    send_cmd(CMD_RELEASE, POOL_MAX - 1);

    // oversized write saturates to a full pool
    set_pool(2047);
    send_cmd(CMD_ALLOC, 0);
    send_cmd(CMD_QUERY, POOL_MAX - 1);
    send_cmd(CMD_RELEASE, POOL_MAX - 1);
    send_cmd(CMD_QUERY, 0);
    send_cmd(CMD_UNUSED, 0);

    // single id pool
    set_pool(1);
    send_cmd(CMD_ALLOC, 0);
    send_cmd(CMD_ALLOC, 0);
    send_cmd(CMD_RELEASE, 0);
    send_cmd(CMD_QUERY, 0);

    // random phases over several pool sizes, last one without idling
    for (int p = 0; p < 9; p++) begin
      set_pool(phase_size[p]);
      idle_pct = phase_idle[p];
      quiet    = (p == 8);
      for (int k = 0; k < phase_items[p]; k++)
        send_cmd(pick_cmd(), pick_id());
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
